>>> src/pstsi_pkg.sv
// Shared types and constants for the per-stage top score insert block.
package pstsi_pkg;

  localparam int CMD_W   = 1;
  localparam int GROUP_W = 2;
  localparam int SCORE_W = 32;
  localparam int INDEX_W = 4;
  localparam int RANK_W  = 4;
  // Largest table address: four rows of at most 32 entries.
  localparam int ADDR_W  = 7;

  typedef logic signed [SCORE_W-1:0] score_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RDWAIT,
    ST_FINISH
  } state_t;

  // One cycle of table traffic from the sequencer.
  typedef struct packed {
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [GROUP_W-1:0] rd_row;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    score_t             wr_data;
    logic               set_valid;
    logic [GROUP_W-1:0] set_row;
  } tbl_req_t;

endpackage

>>> src/pstsi_req_if.sv
// Request channel: command, group, score and entry index.
interface pstsi_req_if;
  import pstsi_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [GROUP_W-1:0] group;
  logic signed [SCORE_W-1:0] score;
  logic [INDEX_W-1:0] entry_index;

  modport source (output valid, cmd, group, score, entry_index, input ready);
  modport sink (input valid, cmd, group, score, entry_index, output ready);
endinterface

>>> src/pstsi_rsp_if.sv
// Response channel: rank of an insert or the value of a read.
interface pstsi_rsp_if;
  import pstsi_pkg::*;

  logic               valid;
  logic               ready;
  logic [RANK_W-1:0]  rank;
  logic signed [SCORE_W-1:0] entry_value;

  modport source (output valid, rank, entry_value, input ready);
  modport sink (input valid, rank, entry_value, output ready);
endinterface

>>> src/pstsi_table.sv
// Score table memory with registered read and per-row valid bits.
module pstsi_table #(
  parameter int RANKS = 10,
  parameter int ROWS  = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  pstsi_pkg::tbl_req_t req,
  output pstsi_pkg::score_t   rd_value
);
  import pstsi_pkg::*;

  localparam int DEPTH = ROWS * RANKS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

  score_t            mem [DEPTH];
  score_t            rd_data;
  logic              rd_row_valid;
  logic [ROWS-1:0]   row_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data      <= mem[req.rd_addr[AW-1:0]];
      rd_row_valid <= row_valid[req.rd_row[RW-1:0]];
    end
  end

  // A row that has never been written reads as all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (req.set_valid) begin
      row_valid[req.set_row[RW-1:0]] <= 1'b1;
    end
  end

  assign rd_value = rd_row_valid ? rd_data : '0;

endmodule

>>> src/per_stage_top_score_insert_top.sv
// Top level of the per-stage top score insert block.
//
// Each group keeps its best RANKS signed scores in descending order, all zero
// after reset. A request beat on req either inserts a score into a group's
// table or reads one stored entry. Every request produces exactly one beat
// on rsp: an insert answers its rank (one plus the number of stored entries
// greater than or equal to the score, RANKS+1 when it does not place) and a
// read answers the stored value, zero for a group or index out of range.
// An insert walks the group's row in the table memory one entry per cycle,
// reading entry k while writing back entry k-1, through the scan state and
// then the finish state; a read passes through the read-wait and finish
// states, and an out-of-range request goes straight to the finish state.
// The single table port pair sets the pace of the walk. req.ready is high
// only while the sequencer is idle. The response sits in an output register,
// so a new request is accepted while the previous beat waits; if rsp stalls,
// the finished result holds in the finish cycle until the register frees up.
// Reset clears the row valid bits at once; no clearing pass is needed.
module per_stage_top_score_insert_top #(
  parameter int RANKS  = 10,
  parameter int STAGES = 4
) (
  input logic         clk,
  input logic         rst,
  pstsi_req_if.sink   req,
  pstsi_rsp_if.source rsp
);
  import pstsi_pkg::*;

  // The group field reaches at most four rows.
  localparam int ROWS = (STAGES < (1 << GROUP_W)) ? STAGES : (1 << GROUP_W);
  localparam int KW   = $clog2(RANKS);
  localparam int CW   = $clog2(RANKS + 2);

  state_t             state, state_next;
  cmd_t               cmd_q;
  logic [GROUP_W-1:0] row_q;
  score_t             score_q;
  logic [ADDR_W-1:0]  base_q;
  logic [KW-1:0]      k;
  logic [CW-1:0]      cnt;
  logic               placed;
  score_t             held;
  logic [RANK_W-1:0]  res_rank;
  score_t             res_value;
  logic               rsp_valid;
  logic [RANK_W-1:0]  rsp_rank;
  score_t             rsp_value;

  tbl_req_t           tbl_req;
  score_t             tbl_rd_value;

  logic               grp_ok, idx_ok, is_read, out_free, last, keep;
  logic [ADDR_W-1:0]  in_base;
  logic [CW-1:0]      cnt_next;
  score_t             wr_value;

  pstsi_table #(
    .RANKS (RANKS),
    .ROWS  (ROWS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (tbl_req),
    .rd_value (tbl_rd_value)
  );

  // Request decode while idle.
  assign grp_ok   = 32'(req.group) < STAGES;
  assign idx_ok   = 32'(req.entry_index) < RANKS;
  assign is_read  = (req.cmd == CMD_READ);
  assign in_base  = ADDR_W'(32'(req.group) * RANKS);
  assign out_free = !rsp_valid || rsp.ready;

  // One step of the merge: entries at or above the new score stay put, the
  // score lands at the first smaller entry, and everything after shifts down.
  assign last     = (k == KW'(RANKS - 1));
  assign keep     = !placed && (tbl_rd_value >= score_q);
  assign cnt_next = cnt + CW'(keep);
  assign wr_value = placed ? held : (keep ? tbl_rd_value : score_q);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (!grp_ok || (is_read && !idx_ok)) begin
            state_next = ST_FINISH;
          end else if (is_read) begin
            state_next = ST_RDWAIT;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_next = ST_FINISH;
        end
      end
      ST_RDWAIT: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready         = 1'b0;
    tbl_req           = '0;
    case (state)
      ST_IDLE: begin
        req.ready       = 1'b1;
        tbl_req.rd_en   = req.valid && grp_ok && (!is_read || idx_ok);
        tbl_req.rd_addr = is_read ? in_base + ADDR_W'(req.entry_index) : in_base;
        tbl_req.rd_row  = req.group;
      end
      ST_SCAN: begin
        tbl_req.wr_en     = 1'b1;
        tbl_req.wr_addr   = base_q + ADDR_W'(k);
        tbl_req.wr_data   = wr_value;
        tbl_req.rd_en     = !last;
        tbl_req.rd_addr   = base_q + ADDR_W'(k) + ADDR_W'(1);
        tbl_req.rd_row    = row_q;
        tbl_req.set_valid = last;
        tbl_req.set_row   = row_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          cmd_q     <= cmd_t'(req.cmd);
          row_q     <= req.group;
          score_q   <= req.score;
          base_q    <= in_base;
          k         <= '0;
          cnt       <= '0;
          placed    <= 1'b0;
          res_rank  <= is_read ? '0 : RANK_W'(RANKS + 1);
          res_value <= '0;
        end
      end
      ST_SCAN: begin
        cnt  <= cnt_next;
        held <= tbl_rd_value;
        k    <= k + KW'(1);
        if (!keep) begin
          placed <= 1'b1;
        end
        if (last) begin
          res_rank <= RANK_W'(32'(cnt_next) + 1);
        end
      end
      ST_RDWAIT: res_value <= tbl_rd_value;
      default: begin
      end
    endcase
  end

  // Output register: loaded when the finish cycle finds it free.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      rsp_rank  <= res_rank;
      rsp_value <= res_value;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.rank        = rsp_rank;
  assign rsp.entry_value = rsp_value;

  // An accepted insert to a live group starts the row walk.
  a_insert_scans: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && !is_read && grp_ok |=> state == ST_SCAN)
    else $error("insert did not start the row walk");

  // The walk index stays inside the row.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> 32'(k) < RANKS)
    else $error("scan index left the row");

  // A finished result is presented on the next cycle when the register frees.
  a_finish_emits: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && out_free |=> rsp.valid && state == ST_IDLE)
    else $error("finished result not presented");

  // Reads always answer rank zero.
  a_read_rank: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && cmd_q == CMD_READ |-> res_rank == '0)
    else $error("read carries a nonzero rank");

endmodule
